@@ hw/rtl/iuwg_pkg.sv @@
package iuwg_pkg;

    // Source picture size and the largest integer scale.
    localparam int SRC_WIDTH  = 320;
    localparam int SRC_HEIGHT = 200;
    localparam int MAX_SCALE  = 8;

    // Field widths.
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int PIX_W   = 32;
    localparam int DIM_W   = 13;
    localparam int PITCH_W = 15;
    localparam int OFF_W   = 26;
    localparam int IDX_W   = 2;
    localparam int SCALE_W = $clog2(MAX_SCALE + 1);
    localparam int SPAN_W  = DIM_W + 1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_DEST_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_DEST_HEIGHT = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_DEST_PITCH  = IDX_W'(2);

    // Geometry derived from the configuration registers.
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [DIM_W-1:0]   off_x;
        logic [DIM_W-1:0]   off_y;
        logic [PITCH_W-1:0] pitch;
        logic               fits;
    } t_geom;

    // Commands to the address unit.
    typedef struct packed {
        logic load;
        logic next_col;
        logic next_row;
    } t_addr_cmd;

endpackage

@@ hw/rtl/iuwg_cfg.sv @@
module iuwg_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [iuwg_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [iuwg_pkg::PITCH_W-1:0] i_cfg_data,
    output iuwg_pkg::t_geom             o_geom
);
    import iuwg_pkg::*;

    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [PITCH_W-1:0] r_pitch;

    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
    logic [SCALE_W-1:0] s;
    logic [SPAN_W-1:0]  span_x;
    logic [SPAN_W-1:0]  span_y;
    logic [SPAN_W-1:0]  diff_x;
    logic [SPAN_W-1:0]  diff_y;

    assign o_cfg_ready = 1'b1;

    // Register writes; an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(640);
            r_height <= DIM_W'(400);
            r_pitch  <= PITCH_W'(2560);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEST_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_DEST_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_DEST_PITCH:  r_pitch  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Each axis scale is the count of multiples of the source size that fit,
    // which saturates at the maximum scale by construction; the smaller one is used, at least one.
    always_comb begin
        sx = '0;
        sy = '0;
        for (int k = 1; k <= MAX_SCALE; k++) begin
            if (int'(r_width) >= SRC_WIDTH * k) begin
                sx = sx + SCALE_W'(1);
            end
            if (int'(r_height) >= SRC_HEIGHT * k) begin
                sy = sy + SCALE_W'(1);
            end
        end
        s = (sx < sy) ? sx : sy;
        if (s == '0) begin
            s = SCALE_W'(1);
        end
    end

    // Centering offsets; they are only used when the picture fits.
    assign span_x = SPAN_W'(SRC_WIDTH) * SPAN_W'(s);
    assign span_y = SPAN_W'(SRC_HEIGHT) * SPAN_W'(s);
    assign diff_x = {1'b0, r_width} - span_x;
    assign diff_y = {1'b0, r_height} - span_y;

    assign o_geom.scale = s;
    assign o_geom.off_x = diff_x[DIM_W:1];
    assign o_geom.off_y = diff_y[DIM_W:1];
    assign o_geom.pitch = r_pitch;
    assign o_geom.fits  = (int'(r_width) >= SRC_WIDTH) && (int'(r_height) >= SRC_HEIGHT);

endmodule

@@ hw/rtl/iuwg_addr.sv @@
module iuwg_addr (
    input  logic                         i_clk,
    input  iuwg_pkg::t_addr_cmd          i_cmd,
    input  logic [iuwg_pkg::DIM_W-1:0]   i_x0,
    input  logic [iuwg_pkg::DIM_W-1:0]   i_y0,
    input  logic [iuwg_pkg::PITCH_W-1:0] i_pitch,
    output logic [iuwg_pkg::OFF_W-1:0]   o_addr
);
    import iuwg_pkg::*;

    localparam int PROD_W = DIM_W + PITCH_W;

    logic [OFF_W-1:0]  r_addr;
    logic [OFF_W-1:0]  r_row;
    logic [PROD_W-1:0] base_prod;
    logic [OFF_W-1:0]  base;
    logic [OFF_W-1:0]  add_a;
    logic [OFF_W-1:0]  add_b;
    logic [OFF_W-1:0]  sum;

    // Start of the block: first row times pitch plus four bytes per column.
    assign base_prod = PROD_W'(i_y0) * PROD_W'(i_pitch);
    assign base      = base_prod[OFF_W-1:0] + OFF_W'({i_x0, 2'b00});

    // Shared adder: steps one pixel right, or one line down from the row start.
    assign add_a = i_cmd.next_row ? r_row : r_addr;
    assign add_b = i_cmd.next_row ? OFF_W'(i_pitch) : OFF_W'(4);
    assign sum   = add_a + add_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= base;
            r_row  <= base;
        end else if (i_cmd.next_row) begin
            r_addr <= sum;
            r_row  <= sum;
        end else if (i_cmd.next_col) begin
            r_addr <= sum;
        end
    end

    assign o_addr = r_addr;

endmodule

@@ hw/rtl/integer_upscale_write_generator.sv @@
// A source pixel is latched in the idle state and placed in the calc and base states;
// its writes are registered out of the emit state, one write per cycle while the receiver does not stall.
// The single shared address adder steps through the scale x scale block, and no new
// pixel is taken until its last write is issued; a pixel with no writes is dropped in idle.
// Reset is synchronous and active low; it restores the default 640x400 geometry.
module integer_upscale_write_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [iuwg_pkg::COL_W-1:0]    i_src_col,
    input  logic [iuwg_pkg::ROW_W-1:0]    i_src_row,
    input  logic [iuwg_pkg::PIX_W-1:0]    i_src_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [iuwg_pkg::OFF_W-1:0]    o_byte_offset,
    output logic [iuwg_pkg::PIX_W-1:0]    o_pixel_out,
    output logic                          o_last_write,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [iuwg_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [iuwg_pkg::PITCH_W-1:0]  i_cfg_data
);
    import iuwg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_BASE,
        ST_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [PIX_W-1:0]   r_pix, n_pix;
    logic [DIM_W-1:0]   r_x0, n_x0;
    logic [DIM_W-1:0]   r_y0, n_y0;
    logic [SCALE_W-1:0] r_dx, n_dx;
    logic [SCALE_W-1:0] r_dy, n_dy;
    logic               r_out_valid, n_out_valid;
    logic [OFF_W-1:0]   r_out_offset, n_out_offset;
    logic [PIX_W-1:0]   r_out_pix, n_out_pix;
    logic               r_out_last, n_out_last;

    t_geom              geom;
    t_addr_cmd          cmd;
    logic [OFF_W-1:0]   addr;
    logic               in_ok;
    logic               slot_free;
    logic [SCALE_W-1:0] last_idx;
    logic               end_col;
    logic               end_row;

    iuwg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    iuwg_addr u_addr (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_x0    (r_x0),
        .i_y0    (r_y0),
        .i_pitch (geom.pitch),
        .o_addr  (addr)
    );

    // A pixel produces writes only if it lies in the source and the picture fits.
    assign in_ok = (int'(i_src_col) < SRC_WIDTH) && (int'(i_src_row) < SRC_HEIGHT)
                   && geom.fits;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign last_idx  = geom.scale - SCALE_W'(1);
    assign end_col   = (r_dx == last_idx);
    assign end_row   = (r_dy == last_idx);
    assign o_in_stall = (r_state != ST_IDLE);

    // Sequencer: latch the pixel, place the block, then walk it row by row.
    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_pix        = r_pix;
        n_x0         = r_x0;
        n_y0         = r_y0;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_out_valid  = r_out_valid;
        n_out_offset = r_out_offset;
        n_out_pix    = r_out_pix;
        n_out_last   = r_out_last;
        cmd          = '0;

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_col = i_src_col;
                    n_row = i_src_row;
                    n_pix = i_src_pixel;
                    if (in_ok) begin
                        n_state = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                n_x0    = geom.off_x + DIM_W'(r_col) * DIM_W'(geom.scale);
                n_y0    = geom.off_y + DIM_W'(r_row) * DIM_W'(geom.scale);
                n_state = ST_BASE;
            end
            ST_BASE: begin
                cmd.load = 1'b1;
                n_dx     = '0;
                n_dy     = '0;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_offset = addr;
                    n_out_pix    = r_pix;
                    n_out_last   = end_col && end_row;
                    if (end_col && end_row) begin
                        n_state = ST_IDLE;
                    end else if (end_col) begin
                        n_dx         = '0;
                        n_dy         = r_dy + SCALE_W'(1);
                        cmd.next_row = 1'b1;
                    end else begin
                        n_dx         = r_dx + SCALE_W'(1);
                        cmd.next_col = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_pix        <= n_pix;
            r_x0         <= n_x0;
            r_y0         <= n_y0;
            r_dx         <= n_dx;
            r_dy         <= n_dy;
            r_out_valid  <= n_out_valid;
            r_out_offset <= n_out_offset;
            r_out_pix    <= n_out_pix;
            r_out_last   <= n_out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_offset = r_out_offset;
    assign o_pixel_out   = r_out_pix;
    assign o_last_write  = r_out_last;

endmodule

@@ tb/sv/tb_integer_upscale_write_generator.sv @@
module tb_integer_upscale_write_generator;

    import iuwg_pkg::*;

    // Index that decodes to no register; writes to it must be dropped.
    localparam logic [IDX_W-1:0] CFG_UNUSED = IDX_W'(3);

    // Cycles allowed after the last write for pixels that produce nothing.
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_fb_write;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [COL_W-1:0]    i_src_col;
    logic [ROW_W-1:0]    i_src_row;
    logic [PIX_W-1:0]    i_src_pixel;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [OFF_W-1:0]    o_byte_offset;
    logic [PIX_W-1:0]    o_pixel_out;
    logic                o_last_write;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [IDX_W-1:0]    i_cfg_index;
    logic [PITCH_W-1:0]  i_cfg_data;

    // Geometry as the block should currently see it.
    logic [DIM_W-1:0]    geo_width;
    logic [DIM_W-1:0]    geo_height;
    logic [PITCH_W-1:0]  geo_pitch;

    t_fb_write           pending_writes[$];
    t_fb_write           want;
    int                  mismatches;
    int                  writes_checked;
    int                  pixels_sent;
    int                  pixels_off_source;
    int                  geometries;
    int                  burst_left;
    int                  stall_run;
    int                  stall_mode;

    integer_upscale_write_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_src_col     (i_src_col),
        .i_src_row     (i_src_row),
        .i_src_pixel   (i_src_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_byte_offset (o_byte_offset),
        .o_pixel_out   (o_pixel_out),
        .o_last_write  (o_last_write),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running clock, period 4.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Works out the framebuffer writes that paint one source pixel.
    function automatic void predict_writes(input logic [COL_W-1:0] col,
                                           input logic [ROW_W-1:0] row,
                                           input logic [PIX_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned scale;
        int unsigned off_x;
        int unsigned off_y;
        int unsigned fx;
        int unsigned fy;
        logic [63:0] addr;
        t_fb_write   held;
        bit          have_held;
        w = geo_width;
        h = geo_height;
        have_held = 1'b0;
        if (col >= SRC_WIDTH || row >= SRC_HEIGHT)
            return;
        scale = (w / SRC_WIDTH < h / SRC_HEIGHT) ? w / SRC_WIDTH : h / SRC_HEIGHT;
        if (scale == 0)
            scale = 1;
        if (scale > MAX_SCALE)
            scale = MAX_SCALE;
        // A destination smaller than the scaled source cannot be centered.
        if (w < SRC_WIDTH * scale || h < SRC_HEIGHT * scale)
            return;
        off_x = (w - SRC_WIDTH * scale) / 2;
        off_y = (h - SRC_HEIGHT * scale) / 2;
        for (int unsigned dy = 0; dy < scale; dy++) begin
            fy = off_y + row * scale + dy;
            if (fy >= h)
                break;
            for (int unsigned dx = 0; dx < scale; dx++) begin
                fx = off_x + col * scale + dx;
                if (fx >= w)
                    continue;
                // Each write is queued once the next one proves it is not the last.
                if (have_held)
                    pending_writes.push_back(held);
                addr = 64'(fy) * 64'(geo_pitch) + 64'(4 * fx);
                held.offset = addr[OFF_W-1:0];
                held.pixel = pix;
                held.last = 1'b0;
                have_held = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            pending_writes.push_back(held);
        end
    endfunction

    // Sends one source pixel; the sender may idle between bursts of random length.
    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic [PIX_W-1:0] pix);
        bit taken;
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        i_in_valid <= 1'b1;
        i_src_col <= col;
        i_src_row <= row;
        i_src_pixel <= pix;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_in_stall === 1'b0);
            @(posedge i_clk);
        end
        predict_writes(col, row, pix);
        pixels_sent++;
        if (col >= SRC_WIDTH || row >= SRC_HEIGHT)
            pixels_off_source++;
    endtask

    // Stops sending and waits until every predicted write has come out.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One configuration beat; valid stays up until the caller releases it.
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [PITCH_W-1:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_cfg_ready === 1'b1);
            @(posedge i_clk);
        end
        case (idx)
            CFG_DEST_WIDTH:  geo_width = data[DIM_W-1:0];
            CFG_DEST_HEIGHT: geo_height = data[DIM_W-1:0];
            CFG_DEST_PITCH:  geo_pitch = data;
            default: ;
        endcase
    endtask

    // Loads a whole geometry once the block has gone quiet.
    task automatic set_geometry(input logic [PITCH_W-1:0] w, input logic [PITCH_W-1:0] h,
                                input logic [PITCH_W-1:0] p);
        wait_idle();
        cfg_write(CFG_DEST_WIDTH, w);
        cfg_write(CFG_DEST_HEIGHT, h);
        cfg_write(CFG_DEST_PITCH, p);
        i_cfg_valid <= 1'b0;
        geometries++;
    endtask

    // Reset geometry, 640x400 at scale two, with corner pixels and extreme values.
    task automatic test_default_geometry();
        send_pixel(0, 0, 32'h0000_0000);
        send_pixel(COL_W'(SRC_WIDTH - 1), ROW_W'(SRC_HEIGHT - 1), 32'hFFFF_FFFF);
        send_pixel(COL_W'(SRC_WIDTH - 1), 0, 32'hA5A5_A5A5);
        send_pixel(0, ROW_W'(SRC_HEIGHT - 1), 32'h5A5A_5A5A);
    endtask

    // Positions past the source picture produce nothing.
    task automatic test_source_out_of_range();
        send_pixel(COL_W'(SRC_WIDTH), 0, 32'h1234_5678);
        send_pixel(0, ROW_W'(SRC_HEIGHT), 32'h8765_4321);
        send_pixel(9'h1FF, 8'hFF, 32'hDEAD_BEEF);
    endtask

    // Upper data bits above a dimension are dropped, and an unused index is ignored.
    task automatic test_register_decoding();
        wait_idle();
        cfg_write(CFG_DEST_WIDTH, 15'h6000 | 15'd640);
        cfg_write(CFG_UNUSED, 15'h7FFF);
        i_cfg_valid <= 1'b0;
        send_pixel(5, 7, 32'hC0FF_EE00);
    endtask

    // Largest destination: scale saturates and the byte offset wraps.
    task automatic test_max_scale();
        set_geometry(15'h1FFF, 15'h1FFF, 15'h7FFF);
        send_pixel(0, 0, 32'h0F0F_0F0F);
        send_pixel(COL_W'(SRC_WIDTH - 1), ROW_W'(SRC_HEIGHT - 1), 32'hF0F0_F0F0);
    endtask

    // Destinations narrower or shorter than the source produce nothing.
    task automatic test_small_destination();
        set_geometry(PITCH_W'(SRC_WIDTH - 1), 400, 2560);
        send_pixel(10, 10, 32'h1111_1111);
        set_geometry(640, PITCH_W'(SRC_HEIGHT - 1), 2560);
        send_pixel(10, 10, 32'h2222_2222);
        set_geometry(0, 0, 0);
        send_pixel(0, 0, 32'h3333_3333);
    endtask

    // Odd margins, a zero and a minimal pitch, and a height-limited scale.
    task automatic test_odd_centering();
        set_geometry(1001, 603, 0);
        send_pixel(1, 2, 32'h4444_4444);
        send_pixel(COL_W'(SRC_WIDTH - 1), ROW_W'(SRC_HEIGHT - 1), 32'h5555_5555);
        set_geometry(1000, 300, 4);
        send_pixel(3, 4, 32'h6666_6666);
        send_pixel(COL_W'(SRC_WIDTH - 1), 0, 32'h7777_7777);
    endtask

    // Random geometries, mostly valid ones with a chosen scale, each with random pixels.
    task automatic test_random_traffic(input int phases, input int per_phase);
        int unsigned s;
        int unsigned w;
        int unsigned h;
        int unsigned p;
        int unsigned pick;
        for (int i = 0; i < phases; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                w = $urandom_range(0, 32767);
                h = $urandom_range(0, 32767);
                p = $urandom_range(0, 32767);
            end else begin
                if (pick < 9)
                    s = 1;
                else if (pick < 14)
                    s = 2;
                else if (pick < 17)
                    s = 3;
                else if (pick < 19)
                    s = 4;
                else
                    s = MAX_SCALE;
                w = SRC_WIDTH * s + $urandom_range(0, ($urandom_range(0, 1) != 0) ? 639 : 40);
                h = SRC_HEIGHT * s + $urandom_range(0, ($urandom_range(0, 1) != 0) ? 399 : 20);
                p = ($urandom_range(0, 2) != 0) ? 4 * w + $urandom_range(0, 64)
                                                : $urandom_range(0, 32767);
            end
            set_geometry(w[PITCH_W-1:0], h[PITCH_W-1:0], p[PITCH_W-1:0]);
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(0, 11) == 0)
                    send_pixel(COL_W'($urandom_range(0, 511)), ROW_W'($urandom_range(0, 255)),
                               $urandom());
                else
                    send_pixel(COL_W'($urandom_range(0, SRC_WIDTH - 1)),
                               ROW_W'($urandom_range(0, SRC_HEIGHT - 1)), $urandom());
            end
        end
    endtask

    // Receiver stalls in stretches: none, light, heavy, or a fixed rhythm.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run = $urandom_range(8, 60);
        end
        stall_run = stall_run - 1;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ((stall_run % 5) < 2);
        endcase
    end

    // Compares each accepted write beat with the oldest prediction.
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            writes_checked++;
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected write: offset %h pixel %h last %b",
                             o_byte_offset, o_pixel_out, o_last_write);
            end else begin
                want = pending_writes.pop_front();
                if (o_byte_offset !== want.offset || o_pixel_out !== want.pixel ||
                    o_last_write !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Write %0d: expected offset %h pixel %h last %b, got %h %h %b",
                                 writes_checked, want.offset, want.pixel, want.last,
                                 o_byte_offset, o_pixel_out, o_last_write);
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_src_col <= '0;
        i_src_row <= '0;
        i_src_pixel <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_DEST_WIDTH;
        i_cfg_data <= '0;
        geo_width = 13'd640;
        geo_height = 13'd400;
        geo_pitch = 15'd2560;
        mismatches = 0;
        writes_checked = 0;
        pixels_sent = 0;
        pixels_off_source = 0;
        geometries = 1;
        burst_left = 0;
        stall_run = 0;
        stall_mode = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_geometry();
        test_source_out_of_range();
        test_register_decoding();
        test_max_scale();
        test_small_destination();
        test_odd_centering();
        test_random_traffic(7, 28);
        wait_idle();

        $display("Sent %0d source pixels (%0d outside the picture) over %0d geometries.",
                 pixels_sent, pixels_off_source, geometries);
        $display("Checked %0d framebuffer writes, %0d of them wrong.",
                 writes_checked, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog for a hung handshake or missing writes.
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/iuwg_pkg.sv
hw/rtl/iuwg_cfg.sv
hw/rtl/iuwg_addr.sv
hw/rtl/integer_upscale_write_generator.sv
tb/sv/tb_integer_upscale_write_generator.sv
